// ===== hdl/spa_pkg.sv =====
package spa_pkg;

  localparam int unsigned MAX_LEN_DEF     = 255;
  localparam int unsigned MAX_ENTRIES_DEF = 4096;

  localparam logic [23:0] WEIGHT_RESET = 24'd65536;

  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_LOAD  = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_ACC   = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic [0:0] REG_WEIGHT = 1'b0;

endpackage

// ===== hdl/sparse_product_accumulate_core.sv =====
// Sparse product accumulate core.
// Clear and write act from the idle state; load reads the row directory, then updates it.
// Read passes the dense cell through a wait state into the output register.
// Accumulate walks the n entries of a row, each through two pipelined multiplies
// and a read-modify-write of the dense cell memory.
// rst_n (sync) clears row valid bits, entry count, output valid and control; weight returns to 1.0.
module sparse_product_accumulate_core #(
  parameter int unsigned MAX_LEN     = spa_pkg::MAX_LEN_DEF,
  parameter int unsigned MAX_ENTRIES = spa_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_row,
  input  logic [7:0]  in_col,
  input  logic [31:0] in_cell_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned EW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = EW + 1;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_LDRD  = 9'b000000010,
    ST_LDWR  = 9'b000000100,
    ST_ACRD  = 9'b000001000,
    ST_ACENT = 9'b000010000,
    ST_ACMUL = 9'b000100000,
    ST_ACCEL = 9'b001000000,
    ST_ACWR  = 9'b010000000,
    ST_RDWT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [23:0] weight_r;
  logic [255:0] row_vld_r;
  logic [CW-1:0] loaded_r;
  logic [7:0] row_r, col_r;
  logic [15:0] val_r;
  logic [CW-1:0] ent_r, ent_end_r;
  logic [CW-1:0] ent_inc;
  logic [39:0] wa_r;
  logic [31:0] prod_r;
  logic [7:0] jcol_r;
  logic [15:0] bval_r;
  logic out_valid_r;
  logic [31:0] out_data_r;

  assign ent_inc = ent_r + 1'b1;

  // row directory: {first, count}
  logic rd_we;
  logic [7:0] rd_waddr, rd_raddr;
  logic [2*CW-1:0] rd_wdata, rd_rdata;
  logic [CW-1:0] rd_first, rd_cnt;
  logic rd_vld_q;
  assign rd_first = rd_vld_q ? rd_rdata[2*CW-1:CW] : '0;
  assign rd_cnt   = rd_vld_q ? rd_rdata[CW-1:0] : '0;

  spa_ram #(.WIDTH(2*CW), .DEPTH(256)) u_dir (
    .clk(clk), .we(rd_we), .waddr(rd_waddr), .wdata(rd_wdata),
    .raddr(rd_raddr), .rdata(rd_rdata)
  );

  logic en_we;
  logic [EW-1:0] en_waddr, en_raddr;
  logic [23:0] en_wdata, en_rdata;

  spa_ram #(.WIDTH(24), .DEPTH(MAX_ENTRIES)) u_ent (
    .clk(clk), .we(en_we), .waddr(en_waddr), .wdata(en_wdata),
    .raddr(en_raddr), .rdata(en_rdata)
  );

  logic dc_we;
  logic [15:0] dc_waddr, dc_raddr;
  logic [31:0] dc_wdata, dc_rdata;

  spa_ram #(.WIDTH(32), .DEPTH(65536)) u_dense (
    .clk(clk), .we(dc_we), .waddr(dc_waddr), .wdata(dc_wdata),
    .raddr(dc_raddr), .rdata(dc_rdata)
  );

  logic acc_in, ok;
  assign ok = (32'(in_row) <= MAX_LEN) && (32'(in_col) <= MAX_LEN);
  assign in_ready = (state_r == ST_IDLE) && !out_valid_r;
  assign acc_in = in_valid && in_ready;

  assign pready = 1'b1;
  assign prdata = {8'd0, weight_r};

  logic [32:0] sum;
  assign sum = {1'b0, dc_rdata} + {1'b0, prod_r};

  always_comb begin
    state_nxt = state_r;
    rd_we = 1'b0;
    rd_waddr = row_r;
    rd_wdata = '0;
    rd_raddr = in_col;
    en_we = 1'b0;
    en_waddr = loaded_r[EW-1:0];
    en_wdata = {col_r, val_r};
    en_raddr = ent_r[EW-1:0];
    dc_we = 1'b0;
    dc_waddr = {row_r, jcol_r};
    dc_wdata = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    dc_raddr = {in_row, in_col};
    case (state_r)
      ST_IDLE: begin
        if (acc_in) begin
          case (in_cmd)
            spa_pkg::CMD_LOAD:  begin
              rd_raddr = in_row;
              if (ok) state_nxt = ST_LDRD;
            end
            spa_pkg::CMD_WRITE: begin
              dc_we = ok;
              dc_waddr = {in_row, in_col};
              dc_wdata = in_cell_value;
            end
            spa_pkg::CMD_ACC: if (ok) state_nxt = ST_ACRD;
            spa_pkg::CMD_READ: state_nxt = ST_RDWT;
            default: ;
          endcase
        end
      end
      ST_LDRD: begin
        rd_raddr = row_r;
        if (loaded_r < CW'(MAX_ENTRIES) &&
            (rd_cnt == '0 || (rd_first + rd_cnt == loaded_r))) begin
          rd_we = 1'b1;
          rd_wdata = {(rd_cnt == '0) ? loaded_r : rd_first, rd_cnt + 1'b1};
          en_we = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_ACRD: begin
        // entry address runs one step ahead so ACENT sees the word of ent_r
        en_raddr = rd_first[EW-1:0];
        state_nxt = ST_ACENT;
      end
      ST_ACENT: begin
        state_nxt = (ent_r >= ent_end_r || 32'(ent_r) >= MAX_ENTRIES) ?
                    ST_IDLE : ST_ACMUL;
      end
      ST_ACMUL: begin
        dc_raddr = {row_r, jcol_r};
        state_nxt = (32'(jcol_r) > MAX_LEN) ? ST_ACWR : ST_ACCEL;
      end
      ST_ACCEL: begin
        dc_raddr = {row_r, jcol_r};
        state_nxt = ST_ACWR;
      end
      ST_ACWR: begin
        dc_we = (32'(jcol_r) <= MAX_LEN);
        en_raddr = ent_inc[EW-1:0];
        state_nxt = ST_ACENT;
      end
      ST_RDWT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // multiply chain: wa = weight*a (40b), then (wa*b)>>32 split in two 20x16 parts
  logic [35:0] ph_r, pl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      weight_r <= spa_pkg::WEIGHT_RESET;
      row_vld_r <= '0;
      loaded_r <= '0;
      out_valid_r <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (psel && penable && pwrite && paddr == {spa_pkg::REG_WEIGHT, 1'b0})
        weight_r <= pwdata[23:0];
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (state_r == ST_IDLE) rd_vld_q <= row_vld_r[rd_raddr];
      if (acc_in && in_cmd == spa_pkg::CMD_CLEAR) begin
        row_vld_r <= '0;
        loaded_r <= '0;
      end
      if (rd_we) begin
        row_vld_r[rd_waddr] <= 1'b1;
        loaded_r <= loaded_r + 1'b1;
      end
      if (state_r == ST_RDWT) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      row_r <= in_row;
      col_r <= in_col;
      val_r <= in_cell_value[15:0];
    end
    if (state_r == ST_RDWT)
      out_data_r <= (32'(row_r) <= MAX_LEN && 32'(col_r) <= MAX_LEN) ? dc_rdata : '0;
    case (state_r)
      ST_ACRD: begin
        ent_r <= rd_first;
        ent_end_r <= rd_first + rd_cnt;
        wa_r <= 40'(weight_r) * 40'(val_r);
      end
      ST_ACENT: begin
        jcol_r <= en_rdata[23:16];
        bval_r <= en_rdata[15:0];
      end
      ST_ACMUL: begin
        ph_r <= 36'(wa_r[39:20]) * 36'(bval_r);
        pl_r <= 36'(wa_r[19:0]) * 36'(bval_r);
      end
      ST_ACCEL: begin
        prod_r <= 32'(({20'd0, ph_r} + 56'(pl_r >> 20)) >> 12);
      end
      ST_ACWR: ent_r <= ent_inc;
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_read_value = out_data_r;

endmodule

// ===== hdl/spa_ram.sv =====
module spa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/spa_checker.sv =====
module spa_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_row,
  input  logic [7:0]  in_col,
  input  logic [31:0] in_cell_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_read_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending,
  output int          reads_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES = spa_pkg::MAX_ENTRIES_DEF;

  logic [23:0] weight_q;
  logic [15:0] ent_val [ENTRIES];
  logic [7:0]  ent_col [ENTRIES];
  logic [12:0] row_base [256];
  logic [12:0] row_cnt [256];
  logic [12:0] n_loaded;
  logic [31:0] dense [65536];
  logic [31:0] read_q [$];

  task automatic append_entry(input logic [7:0] r, input logic [7:0] c, input logic [15:0] v);
    logic [12:0] n;
    n = row_cnt[r];
    if (n_loaded >= ENTRIES) return;
    if (n != 0 && row_base[r] + n != n_loaded) return;
    if (n == 0) row_base[r] = n_loaded;
    ent_val[n_loaded] = v;
    ent_col[n_loaded] = c;
    n_loaded = n_loaded + 1'b1;
    row_cnt[r] = n + 1'b1;
  endtask

  task automatic relax_row(input logic [7:0] i, input logic [7:0] k, input logic [15:0] a);
    logic [39:0] wa;
    logic [55:0] prod;
    logic [32:0] sum;
    int unsigned e;
    logic [15:0] idx;
    wa = weight_q * a;
    for (int t = 0; t < row_cnt[k]; t++) begin
      e = 32'(row_base[k]) + 32'(t);
      if (e >= ENTRIES) break;
      if (ent_col[e] > spa_pkg::MAX_LEN_DEF) continue;
      idx = {i, ent_col[e]};
      prod = wa * ent_val[e];
      sum = {1'b0, dense[idx]} + {1'b0, prod[55:32]};
      dense[idx] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end
  endtask

  always @(posedge clk) begin
    logic ok;
    logic [31:0] want;
    if (!rst_n) begin
      weight_q <= spa_pkg::WEIGHT_RESET;
      n_loaded = '0;
      for (int r = 0; r < 256; r++) row_cnt[r] = '0;
      errors <= 0;
      reads_checked <= 0;
      read_q.delete();
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[1:0] == {spa_pkg::REG_WEIGHT, 1'b0})
        weight_q <= pwdata[23:0];
      if (in_valid && in_ready) begin
        ok = in_row <= spa_pkg::MAX_LEN_DEF && in_col <= spa_pkg::MAX_LEN_DEF;
        case (in_cmd)
          spa_pkg::CMD_CLEAR: begin
            for (int r = 0; r < 256; r++) row_cnt[r] = '0;
            n_loaded = '0;
          end
          spa_pkg::CMD_LOAD:  if (ok) append_entry(in_row, in_col, in_cell_value[15:0]);
          spa_pkg::CMD_WRITE: if (ok) dense[{in_row, in_col}] = in_cell_value;
          spa_pkg::CMD_ACC:   if (ok) relax_row(in_row, in_col, in_cell_value[15:0]);
          spa_pkg::CMD_READ:  read_q.push_back(ok ? dense[{in_row, in_col}] : 32'h0);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (read_q.size() == 0) begin
          $error("unexpected read word: read_value %h", out_read_value);
          errors <= errors + 1;
        end else begin
          want = read_q.pop_front();
          reads_checked <= reads_checked + 1;
          if (out_read_value !== want) begin
            $error("read_value mismatch: expected %h actual %h", want, out_read_value);
            errors <= errors + 1;
          end
        end
      end
      pending <= read_q.size();
    end
  end
endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
  localparam logic [2:0] CMD_UNUSED_MID = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;
  localparam int IDLE_LIMIT = 60000;
  // longest accumulate: a row holding the whole store
  localparam int DRAIN_CYCLES = 4 * spa_pkg::MAX_ENTRIES_DEF + 100;
  localparam int PHASE_ITEMS = 130;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [2:0] in_cmd;
  logic [7:0] in_row, in_col;
  logic [31:0] in_cell_value, out_read_value;
  logic psel, penable, pwrite, pready;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;
  int errors, pending, reads_checked;
  logic in_taken;
  int idle_cycles, sent, out_stall;
  bit quiet;

  sparse_product_accumulate_core u_dut (.*);

  spa_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    idle_cycles = 0;
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // receiver stalls
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 0;
    end else begin
      out_ready <= 1;
      if (!quiet && $urandom_range(0, 99) < 30)
        out_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send(input logic [2:0] c, input logic [7:0] r, input logic [7:0] k,
                      input logic [31:0] v);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1;
    in_cmd <= c;
    in_row <= r;
    in_col <= k;
    in_cell_value <= v;
    do @(negedge clk); while (!in_taken);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(negedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_weight(input logic [23:0] w);
    drain();
    psel <= 1;
    pwrite <= 1;
    paddr <= {spa_pkg::REG_WEIGHT, 1'b0};
    pwdata <= {8'h0, w};
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(negedge clk);
  endtask

  // dense cells touched are confined to rows/cols in {0..7, 248..255}, all written up front
  function automatic logic [7:0] pick_idx();
    logic [7:0] x;
    x = 8'($urandom_range(0, 7));
    return ($urandom_range(0, 1) != 0) ? x : 8'd248 + x;
  endfunction

  function automatic logic [31:0] pick_cell();
    case ($urandom_range(0, 3))
      0: return 32'hFFFF_FFFF - $urandom_range(0, 255);
      1: return $urandom;
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  task automatic random_item();
    int r, nrows, nent;
    logic [7:0] lrow;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      // well-formed reload: clear, then rows one after another
      send(spa_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom), $urandom);
      nrows = $urandom_range(1, 6);
      for (int i = 0; i < nrows; i++) begin
        lrow = 8'($urandom_range(0, 255));
        nent = $urandom_range(1, 5);
        for (int j = 0; j < nent; j++) send(spa_pkg::CMD_LOAD, lrow, pick_idx(), $urandom);
      end
    end else if (r < 45) begin
      send(spa_pkg::CMD_ACC, pick_idx(), 8'($urandom_range(0, 255)), $urandom);
    end else if (r < 70) begin
      send(spa_pkg::CMD_READ, pick_idx(), pick_idx(), $urandom);
    end else if (r < 85) begin
      send(spa_pkg::CMD_WRITE, pick_idx(), pick_idx(), pick_cell());
    end else if (r < 95) begin
      send(spa_pkg::CMD_LOAD, 8'($urandom), pick_idx(), $urandom);
    end else if (r < 98) begin
      send(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), 8'($urandom), 8'($urandom),
           $urandom);
    end else begin
      send(spa_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom), $urandom);
    end
  endtask

  initial begin
    logic [23:0] weights [4];
    rst_n = 0;
    in_valid = 0;
    in_cmd = spa_pkg::CMD_CLEAR;
    in_row = 0;
    in_col = 0;
    in_cell_value = 0;
    out_ready = 1;
    out_stall = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    sent = 0;
    quiet = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // every dense cell in the working window gets a value first
    quiet = 1;
    for (int i = 0; i < 16; i++)
      for (int j = 0; j < 16; j++)
        send(spa_pkg::CMD_WRITE, (i < 8) ? 8'(i) : 8'(240 + i),
             (j < 8) ? 8'(j) : 8'(240 + j), pick_cell());
    quiet = 0;

    // directed
    send(spa_pkg::CMD_WRITE, 8'd0, 8'd0, 32'h0);
    send(spa_pkg::CMD_WRITE, 8'd255, 8'd255, 32'hFFFF_FFF0);
    send(spa_pkg::CMD_LOAD, 8'd3, 8'd0, 32'hFFFF_FFFF);
    send(spa_pkg::CMD_LOAD, 8'd3, 8'd255, 32'h0001_8000);
    send(spa_pkg::CMD_LOAD, 8'd255, 8'd7, 32'h0000_FFFF);
    send(spa_pkg::CMD_LOAD, 8'd3, 8'd1, 32'h1234);       // row 3 no longer last: dropped
    send(spa_pkg::CMD_ACC, 8'd0, 8'd3, 32'h0000_FFFF);
    send(spa_pkg::CMD_ACC, 8'd255, 8'd3, 32'hFFFF_FFFF); // saturates cell (255,255)
    send(spa_pkg::CMD_ACC, 8'd7, 8'd100, 32'hFFFF);      // empty row
    send(spa_pkg::CMD_ACC, 8'd248, 8'd255, 32'h0);
    send(spa_pkg::CMD_READ, 8'd0, 8'd0, 32'h0);
    send(spa_pkg::CMD_READ, 8'd255, 8'd255, 32'hFFFF_FFFF);
    send(spa_pkg::CMD_READ, 8'd0, 8'd255, 32'h0);
    send(spa_pkg::CMD_READ, 8'd7, 8'd7, 32'h0);
    send(CMD_UNUSED_LO, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send(CMD_UNUSED_MID, 8'h00, 8'h00, 32'h0);
    send(CMD_UNUSED_HI, 8'hAA, 8'h55, 32'h5555_AAAA);
    send(spa_pkg::CMD_CLEAR, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send(spa_pkg::CMD_ACC, 8'd0, 8'd3, 32'hFFFF);        // cleared: no effect
    send(spa_pkg::CMD_READ, 8'd0, 8'd255, 32'h0);

    for (int j = 0; j < 20; j++) begin
      send(spa_pkg::CMD_ACC, pick_idx(), 8'($urandom_range(0, 255)), $urandom);
      send(spa_pkg::CMD_READ, pick_idx(), pick_idx(), 32'h0);
    end

    weights[0] = 24'd0;
    weights[1] = 24'hFF_FFFF;
    weights[2] = 24'($urandom_range(1, 24'hFF_FFFF));
    weights[3] = 24'($urandom_range(1, 24'h02_0000));
    for (int p = 0; p < 5; p++) begin
      if (p > 0) set_weight(weights[p - 1]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 45 == 0) quiet = $urandom_range(0, 2) == 0;
        if (n == PHASE_ITEMS / 2) begin
          in_valid <= 0;
          @(negedge clk);
          wait (pending == 0);
          @(negedge clk);
        end
        random_item();
      end
      quiet = 0;
    end

    drain();
    $display("Run covered %0d input words over five weight settings, zero and full scale too,",
             sent);
    $display("with saturating sums, dropped loads, idle commands and %0d checked reads.",
             reads_checked);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/spa_pkg.sv
hdl/spa_ram.sv
hdl/sparse_product_accumulate_core.sv
tb/spa_checker.sv
tb/testbench.sv
